### src/lctg_pkg.sv
// Package for the cell topology generator: generator constants, microcode
// field types, control and status structs and the microcode table.
// No dependencies; used by lctg_seq, lctg_dp and the top level.
`default_nettype none

package lctg_pkg;

  // 64-bit MMIX generator step
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
  localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
  localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

  // Fixed moduli and their truncated reciprocals (floor(2^32 / m))
  localparam logic [4:0]  ENDO_COUNT = 5'd27;
  localparam logic [5:0]  CHAIN_LEN  = 6'd60;
  localparam logic [7:0]  CHAIN_LEN8 = 8'd60;
  localparam logic [32:0] RCP_ENDO   = 33'((64'd1 << 32) / 64'd27);
  localparam logic [32:0] RCP_LEN    = 33'((64'd1 << 32) / 64'd60);

  // Mode register codes
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_LAYERED = 2'd1;
  localparam logic [1:0] MODE_CHAIN   = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] CFG_MODE = 1'b0;
  localparam logic [0:0] CFG_SEED = 1'b1;

  // Microcode program counter
  localparam int PC_W = 7;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ENTRY_UNIFORM = 7'd0;
  localparam pc_t ENTRY_LAYERED = 7'd19;
  localparam pc_t ENTRY_CHAIN   = 7'd34;

  // Datapath operations, one per step
  typedef enum logic [2:0] {
    OP_ADV0,   // low partial product of the generator step
    OP_ADV1,   // first cross product
    OP_ADV2,   // second cross product, commit new generator value
    OP_RECIP,  // quotient estimate by reciprocal multiply
    OP_QM,     // remainder estimate
    OP_FIX,    // correct remainder and write it
    OP_PUT,    // move a value without arithmetic
    OP_DONE    // hand the item to the output register
  } op_t;

  // Write targets
  typedef enum logic [3:0] {
    W_NONE,
    W_ENDO,
    W_SRC,
    W_DST,
    W_SRC_CHAIN,
    W_DST_CHAIN,
    W_CHAIN,
    W_SRC_PHASE,
    W_DST_SRC
  } wsel_t;

  // Modulus select
  typedef enum logic [1:0] {
    M_NONE,
    M_ENDO,
    M_LEN,
    M_CHAN
  } msel_t;

  // Jump conditions
  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_BIT33,
    J_FAR
  } jcond_t;

  typedef struct packed {
    op_t    op;
    wsel_t  wsel;
    msel_t  msel;
    jcond_t jc;
    pc_t    target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic  en;
    op_t   op;
    wsel_t wsel;
    msel_t msel;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic bit33;  // bit 33 of the generator value
    logic far;    // bits 34:33 both set: inter-chain branch
  } stat_t;

  function automatic uword_t uw(op_t op, wsel_t ws, msel_t ms, jcond_t jc, pc_t tg);
    uword_t w;
    w.op     = op;
    w.wsel   = ws;
    w.msel   = ms;
    w.jc     = jc;
    w.target = tg;
    return w;
  endfunction

  // Microcode program. Most draws are ADV0, ADV1, ADV2, RECIP, QM, FIX.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      // generator steps
      7'd0, 7'd6, 7'd12, 7'd20, 7'd27, 7'd34, 7'd38, 7'd44, 7'd50, 7'd54, 7'd60:
        w = uw(OP_ADV0, W_NONE, M_NONE, J_NEXT, 7'd0);
      7'd1, 7'd7, 7'd13, 7'd21, 7'd28, 7'd35, 7'd39, 7'd45, 7'd51, 7'd55, 7'd61:
        w = uw(OP_ADV1, W_NONE, M_NONE, J_NEXT, 7'd0);
      7'd2, 7'd8, 7'd14, 7'd22, 7'd29, 7'd36, 7'd40, 7'd46, 7'd52, 7'd56, 7'd62:
        w = uw(OP_ADV2, W_NONE, M_NONE, J_NEXT, 7'd0);
      // uniform: endo, src, dst
      7'd3:  w = uw(OP_RECIP, W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd4:  w = uw(OP_QM,    W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd5:  w = uw(OP_FIX,   W_ENDO, M_ENDO, J_NEXT, 7'd0);
      7'd9:  w = uw(OP_RECIP, W_NONE, M_CHAN, J_NEXT, 7'd0);
      7'd10: w = uw(OP_QM,    W_NONE, M_CHAN, J_NEXT, 7'd0);
      7'd11: w = uw(OP_FIX,   W_SRC,  M_CHAN, J_NEXT, 7'd0);
      7'd15: w = uw(OP_RECIP, W_NONE, M_CHAN, J_NEXT, 7'd0);
      7'd16: w = uw(OP_QM,    W_NONE, M_CHAN, J_NEXT, 7'd0);
      7'd17: w = uw(OP_FIX,   W_DST,  M_CHAN, J_NEXT, 7'd0);
      7'd18: w = uw(OP_DONE,  W_NONE, M_NONE, J_NEXT, 7'd0);
      // layered: src from counter, residual copy on bit 33
      7'd19: w = uw(OP_PUT,   W_SRC_PHASE, M_NONE, J_NEXT, 7'd0);
      7'd23: w = uw(OP_RECIP, W_NONE, M_CHAN, J_BIT33, 7'd26);
      7'd24: w = uw(OP_QM,    W_NONE, M_CHAN, J_NEXT, 7'd0);
      7'd25: w = uw(OP_FIX,   W_DST,  M_CHAN, J_ALWAYS, 7'd27);
      7'd26: w = uw(OP_PUT,   W_DST_SRC, M_NONE, J_NEXT, 7'd0);
      7'd30: w = uw(OP_RECIP, W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd31: w = uw(OP_QM,    W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd32: w = uw(OP_FIX,   W_ENDO, M_ENDO, J_NEXT, 7'd0);
      7'd33: w = uw(OP_DONE,  W_NONE, M_NONE, J_NEXT, 7'd0);
      // chain local: chain, offset, then near or far destination
      7'd37: w = uw(OP_PUT,   W_CHAIN, M_NONE, J_NEXT, 7'd0);
      7'd41: w = uw(OP_RECIP, W_NONE, M_LEN, J_NEXT, 7'd0);
      7'd42: w = uw(OP_QM,    W_NONE, M_LEN, J_NEXT, 7'd0);
      7'd43: w = uw(OP_FIX,   W_SRC_CHAIN, M_LEN, J_NEXT, 7'd0);
      7'd47: w = uw(OP_RECIP, W_NONE, M_LEN, J_FAR, 7'd50);
      7'd48: w = uw(OP_QM,    W_NONE, M_LEN, J_NEXT, 7'd0);
      7'd49: w = uw(OP_FIX,   W_DST_CHAIN, M_LEN, J_ALWAYS, 7'd60);
      7'd53: w = uw(OP_PUT,   W_CHAIN, M_NONE, J_NEXT, 7'd0);
      7'd57: w = uw(OP_RECIP, W_NONE, M_LEN, J_NEXT, 7'd0);
      7'd58: w = uw(OP_QM,    W_NONE, M_LEN, J_NEXT, 7'd0);
      7'd59: w = uw(OP_FIX,   W_DST_CHAIN, M_LEN, J_NEXT, 7'd0);
      7'd63: w = uw(OP_RECIP, W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd64: w = uw(OP_QM,    W_NONE, M_ENDO, J_NEXT, 7'd0);
      7'd65: w = uw(OP_FIX,   W_ENDO, M_ENDO, J_NEXT, 7'd0);
      default: w = uw(OP_DONE, W_NONE, M_NONE, J_NEXT, 7'd0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/lcg_cell_topology_generator_top.sv
// One item at a time: in_ready is low from accept until the item is handed
// to the output register, which can stall on out_ready. The pace is set by
// the shared 32x33 multiplier, three steps per generator advance and three
// per reduction.
// Reset (synchronous, rst_n low): mode, seed, generator and counter clear.
// Top level: config registers, output register, sequencer and datapath.
`default_nettype none

module lcg_cell_topology_generator_top #(
  parameter int CHANNELS = 240
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_endo_code,
  output logic [7:0]       out_src_channel,
  output logic [7:0]       out_dst_channel,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  logic [1:0]  mode_r;
  logic [63:0] seed_r;
  logic        out_valid_r;
  logic [4:0]  out_endo_r;
  logic [7:0]  out_src_r;
  logic [7:0]  out_dst_r;

  logic             start;
  logic             done;
  logic             idle;
  logic             out_free;
  lctg_pkg::ctrl_t  ctrl;
  lctg_pkg::stat_t  stat;
  logic [4:0]       dp_endo;
  logic [7:0]       dp_src;
  logic [7:0]       dp_dst;

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign out_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lctg_pkg::MODE_UNIFORM;
      seed_r <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lctg_pkg::CFG_MODE: mode_r <= cfg_wdata[1:0];
        lctg_pkg::CFG_SEED: seed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lctg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .mode     (mode_r),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .done     (done),
    .idle     (idle)
  );

  lctg_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .restart     (in_restart),
    .seed        (seed_r),
    .ctrl        (ctrl),
    .done        (done),
    .stat        (stat),
    .endo_code   (dp_endo),
    .src_channel (dp_src),
    .dst_channel (dp_dst)
  );

  // output register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_endo_r <= dp_endo;
      out_src_r  <= dp_src;
      out_dst_r  <= dp_dst;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_endo_code   = out_endo_r;
  assign out_src_channel = out_src_r;
  assign out_dst_channel = out_dst_r;

`ifndef SYNTHESIS
  // an accepted item keeps the sequencer busy for at least one step
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  // completion always shows up at the output
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid)
    else $error("completed item not presented at the output");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !done)
    else $error("completion while the output register is stalled");

  // endomorphism code stays in range
  a_endo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_endo_code <= 5'd26))
    else $error("endomorphism code out of range");
`endif

endmodule

`default_nettype wire

### src/lctg_seq.sv
// Microcode sequencer: step counter over the table in lctg_pkg, mode
// dispatch at start, conditional jumps on datapath status.
// Depends on lctg_pkg.
`default_nettype none

module lctg_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      mode,
  input  wire lctg_pkg::stat_t stat,
  input  wire logic            out_free,
  output lctg_pkg::ctrl_t      ctrl,
  output logic                 done,
  output logic                 idle
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t             state_r;
  lctg_pkg::pc_t      pc_r;
  lctg_pkg::uword_t   uword;
  lctg_pkg::pc_t      entry;
  logic               take;

  assign uword = lctg_pkg::ucode(pc_r);

  // pick the program for the mode; the unused code runs the uniform one
  always_comb begin
    unique case (mode)
      lctg_pkg::MODE_LAYERED: entry = lctg_pkg::ENTRY_LAYERED;
      lctg_pkg::MODE_CHAIN:   entry = lctg_pkg::ENTRY_CHAIN;
      default:                entry = lctg_pkg::ENTRY_UNIFORM;
    endcase
  end

  // evaluate jump condition
  always_comb begin
    unique case (uword.jc)
      lctg_pkg::J_ALWAYS: take = 1'b1;
      lctg_pkg::J_BIT33:  take = stat.bit33;
      lctg_pkg::J_FAR:    take = stat.far;
      default:            take = 1'b0;
    endcase
  end

  // drive the datapath from the current control word
  always_comb begin
    ctrl.en   = (state_r == S_RUN);
    ctrl.op   = uword.op;
    ctrl.wsel = uword.wsel;
    ctrl.msel = uword.msel;
  end

  assign done = (state_r == S_RUN) && (uword.op == lctg_pkg::OP_DONE) && out_free;
  assign idle = (state_r == S_IDLE);

  // advance step counter; hold on the final step until the output is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= lctg_pkg::ENTRY_UNIFORM;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            pc_r    <= entry;
          end
        end
        S_RUN: begin
          if (uword.op == lctg_pkg::OP_DONE) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else if (take) begin
            pc_r <= uword.target;
          end else begin
            pc_r <= pc_r + lctg_pkg::pc_t'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/lctg_dp.sv
// Datapath: generator value, one shared 32x33 multiplier for generator
// steps and constant reductions, cell counter and the result fields.
// Depends on lctg_pkg; driven by lctg_seq through ctrl.
`default_nettype none

module lctg_dp #(
  parameter int CHANNELS = 240
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            restart,
  input  wire logic [63:0]     seed,
  input  wire lctg_pkg::ctrl_t ctrl,
  input  wire logic            done,
  output lctg_pkg::stat_t      stat,
  output logic [4:0]           endo_code,
  output logic [7:0]           src_channel,
  output logic [7:0]           dst_channel
);

  localparam int M_MAX = (CHANNELS > 60) ? CHANNELS : 60;
  localparam int M_W   = $clog2(M_MAX + 1);
  localparam int REM_W = $clog2(2 * M_MAX);
  localparam int PH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [32:0]    RCP_CHAN = 33'((64'd1 << 32) / 64'(CHANNELS));
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(CHANNELS - 1);

  logic [63:0]      lcg_r;
  logic [PH_W-1:0]  phase_r;
  logic [63:0]      p_r;
  logic [31:0]      t_r;
  logic [31:0]      q_r;
  logic [REM_W-1:0] rem_r;
  logic [1:0]       c_r;
  logic [4:0]       endo_r;
  logic [7:0]       src_r;
  logic [7:0]       dst_r;

  logic [31:0]      draw;
  logic [31:0]      mul_a;
  logic [32:0]      mul_b;
  logic [64:0]      prod;
  logic [M_W-1:0]   modv;
  logic [32:0]      rcp;
  logic [31:0]      diff;
  logic [REM_W-1:0] fixv;
  logic [7:0]       chain_base;

  assign draw = lcg_r[63:32];

  // modulus and reciprocal for the selected reduction
  always_comb begin
    unique case (ctrl.msel)
      lctg_pkg::M_ENDO: begin
        modv = M_W'(lctg_pkg::ENDO_COUNT);
        rcp  = lctg_pkg::RCP_ENDO;
      end
      lctg_pkg::M_LEN: begin
        modv = M_W'(lctg_pkg::CHAIN_LEN);
        rcp  = lctg_pkg::RCP_LEN;
      end
      lctg_pkg::M_CHAN: begin
        modv = M_W'(CHANNELS);
        rcp  = RCP_CHAN;
      end
      default: begin
        modv = M_W'(1);
        rcp  = 33'd0;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.op)
      lctg_pkg::OP_ADV0: begin
        mul_a = lcg_r[31:0];
        mul_b = {1'b0, lctg_pkg::LCG_MUL_LO};
      end
      lctg_pkg::OP_ADV1: begin
        mul_a = lcg_r[31:0];
        mul_b = {1'b0, lctg_pkg::LCG_MUL_HI};
      end
      lctg_pkg::OP_ADV2: begin
        mul_a = lcg_r[63:32];
        mul_b = {1'b0, lctg_pkg::LCG_MUL_LO};
      end
      lctg_pkg::OP_RECIP: begin
        mul_a = draw;
        mul_b = rcp;
      end
      lctg_pkg::OP_QM: begin
        mul_a = q_r;
        mul_b = 33'(modv);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 33'd0;
      end
    endcase
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  // remainder estimate is below twice the modulus; one correction settles it
  assign diff       = draw - prod[31:0];
  assign fixv       = (rem_r >= REM_W'(modv)) ? (rem_r - REM_W'(modv)) : rem_r;
  assign chain_base = 8'({6'd0, c_r} * lctg_pkg::CHAIN_LEN8);

  // generator value and cell counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r   <= 64'd0;
      phase_r <= '0;
    end else begin
      if (start && restart) begin
        lcg_r   <= seed;
        phase_r <= '0;
      end else begin
        if (ctrl.en && (ctrl.op == lctg_pkg::OP_ADV2)) begin
          lcg_r <= {t_r + prod[31:0], p_r[31:0]} + lctg_pkg::LCG_ADD;
        end
        if (done) begin
          phase_r <= (phase_r == PH_LAST) ? '0 : phase_r + PH_W'(1);
        end
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.op)
        lctg_pkg::OP_ADV0:  p_r <= prod[63:0];
        lctg_pkg::OP_ADV1:  t_r <= p_r[63:32] + prod[31:0];
        lctg_pkg::OP_RECIP: q_r <= prod[63:32];
        lctg_pkg::OP_QM:    rem_r <= diff[REM_W-1:0];
        lctg_pkg::OP_FIX: begin
          unique case (ctrl.wsel)
            lctg_pkg::W_ENDO:      endo_r <= 5'(fixv);
            lctg_pkg::W_SRC:       src_r  <= 8'(fixv);
            lctg_pkg::W_DST:       dst_r  <= 8'(fixv);
            lctg_pkg::W_SRC_CHAIN: src_r  <= chain_base + 8'(fixv);
            lctg_pkg::W_DST_CHAIN: dst_r  <= chain_base + 8'(fixv);
            default: ;
          endcase
        end
        lctg_pkg::OP_PUT: begin
          unique case (ctrl.wsel)
            lctg_pkg::W_CHAIN:     c_r   <= lcg_r[33:32];
            lctg_pkg::W_SRC_PHASE: src_r <= 8'(phase_r);
            lctg_pkg::W_DST_SRC:   dst_r <= src_r;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign stat.bit33  = lcg_r[33];
  assign stat.far    = (lcg_r[34:33] == 2'b11);
  assign endo_code   = endo_r;
  assign src_channel = src_r;
  assign dst_channel = dst_r;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for lcg_cell_topology_generator_top: drives restart items,
// predicts each cell descriptor from a local copy of the generator and counter.
// Depends on lctg_pkg (mode and register codes) and the top level RTL.

module tb_top;

  localparam logic [31:0] CELL_CHANNELS  = 32'd240;
  localparam logic [63:0] GEN_MUL        = 64'd6364136223846793005;
  localparam logic [63:0] GEN_ADD        = 64'd1442695040888963407;
  localparam logic [31:0] ENDO_KINDS     = 32'd27;
  localparam logic [31:0] CHAIN_SPAN     = 32'd60;
  localparam logic [31:0] CHAIN_NUM      = 32'd4;
  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  localparam int          DRAIN_GAP      = 40;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [4:0] endo;
    logic [7:0] src;
    logic [7:0] dst;
  } cell_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_endo_code;
  logic [7:0]  out_src_channel;
  logic [7:0]  out_dst_channel;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = 1'b0;
  logic [63:0] cfg_wdata = 64'd0;

  // local copy of block state and registers
  logic [63:0] gen_state = 64'd0;
  logic [7:0]  cell_count = 8'd0;
  logic [1:0]  mode_reg = lctg_pkg::MODE_UNIFORM;
  logic [63:0] seed_reg = 64'd0;

  logic        pending_requests[$];
  cell_t       expected_cells[$];
  bit          in_busy = 1'b0;
  bit          drain_hold = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  lcg_cell_topology_generator_top #(.CHANNELS(240)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_endo_code   (out_endo_code),
    .out_src_channel (out_src_channel),
    .out_dst_channel (out_dst_channel),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // advance the generator and return the upper word of the new value
  function automatic logic [31:0] draw_upper();
    gen_state = gen_state * GEN_MUL + GEN_ADD;
    return gen_state[63:32];
  endfunction

  // compute the descriptor for one request and advance the counter
  function automatic cell_t predict_cell(input logic restart);
    cell_t       c;
    logic [31:0] r;
    logic [31:0] chain;
    logic [31:0] chain2;
    if (restart) begin
      gen_state  = seed_reg;
      cell_count = 8'd0;
    end
    case (mode_reg)
      lctg_pkg::MODE_LAYERED: begin
        c.src = cell_count;
        r = draw_upper();
        // bit 33 of the generator value selects a residual copy
        if (r[1]) c.dst = c.src;
        else c.dst = 8'(r % CELL_CHANNELS);
        c.endo = 5'(draw_upper() % ENDO_KINDS);
      end
      lctg_pkg::MODE_CHAIN: begin
        chain = draw_upper() % CHAIN_NUM;
        c.src = 8'(chain * CHAIN_SPAN + draw_upper() % CHAIN_SPAN);
        r = draw_upper();
        // bits 34:33 both set take the inter-chain branch
        if (r[2:1] != 2'b11) begin
          c.dst = 8'(chain * CHAIN_SPAN + r % CHAIN_SPAN);
        end else begin
          chain2 = draw_upper() % CHAIN_NUM;
          c.dst = 8'(chain2 * CHAIN_SPAN + draw_upper() % CHAIN_SPAN);
        end
        c.endo = 5'(draw_upper() % ENDO_KINDS);
      end
      default: begin
        c.endo = 5'(draw_upper() % ENDO_KINDS);
        c.src  = 8'(draw_upper() % CELL_CHANNELS);
        c.dst  = 8'(draw_upper() % CELL_CHANNELS);
      end
    endcase
    if (cell_count == 8'(CELL_CHANNELS - 1)) cell_count = 8'd0;
    else cell_count = cell_count + 8'd1;
    return c;
  endfunction

  // present the next request at the falling edge
  always @(negedge clk) begin
    if (rst_n && !in_busy) begin
      if (drain_hold && expected_cells.size() == 0) drain_hold = 1'b0;
      if (pending_requests.size() != 0 && !drain_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_restart <= pending_requests[0];
        in_busy = 1'b1;
      end else begin
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(1));
      end
    end
  end

  // stall the result channel at random
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // record accepted requests and their predicted descriptors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_cells.push_back(predict_cell(in_restart));
      void'(pending_requests.pop_front());
      in_busy = 1'b0;
      // now and then hold the sender until every result is back
      if ($urandom_range(99) < 2) drain_hold = 1'b1;
    end
  end

  // compare each accepted descriptor with the oldest prediction
  always @(posedge clk) begin
    cell_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected cell endo %0d src %0d dst %0d", $time,
                   out_endo_code, out_src_channel, out_dst_channel);
      end else begin
        want = expected_cells.pop_front();
        if (want.endo !== out_endo_code || want.src !== out_src_channel ||
            want.dst !== out_dst_channel) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: cell mismatch, expected endo %0d src %0d dst %0d, got %0d %0d %0d",
                     $time, want.endo, want.src, want.dst,
                     out_endo_code, out_src_channel, out_dst_channel);
        end
      end
    end
  end

  // end the run when work is pending but nothing moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_requests.size() == 0 && expected_cells.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == lctg_pkg::CFG_MODE) mode_reg = data[1:0];
    else seed_reg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is taken and every result is back
  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_cells.size() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic queue_requests(input int count, input bit first_restart);
    for (int i = 0; i < count; i++)
      pending_requests.push_back(i == 0 ? first_restart : 1'b0);
  endtask

  initial begin
    int          block_len;
    logic [1:0]  blk_mode;
    logic [63:0] blk_seed;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset registers: uniform mode, zero seed, run on from zero then reload
    queue_requests(2, 1'b0);
    pending_requests.push_back(1'b1);
    wait_drained();

    // layered with all-ones seed; mode written with upper bits set
    write_reg(lctg_pkg::CFG_SEED, '1);
    write_reg(lctg_pkg::CFG_MODE, {62'h3FFF_FFFF_FFFF_FFFF, lctg_pkg::MODE_LAYERED});
    queue_requests(5, 1'b1);
    pending_requests.push_back(1'b1);
    wait_drained();

    write_reg(lctg_pkg::CFG_SEED, 64'h0123_4567_89AB_CDEF);
    write_reg(lctg_pkg::CFG_MODE, 64'(lctg_pkg::MODE_CHAIN));
    queue_requests(6, 1'b1);
    wait_drained();

    // unused mode code falls back to uniform
    write_reg(lctg_pkg::CFG_SEED, 64'd0);
    write_reg(lctg_pkg::CFG_MODE, 64'(MODE_SPARE));
    queue_requests(3, 1'b1);
    wait_drained();

    // random blocks: modes rotated through four idle profiles
    for (int blk = 0; blk < 12; blk++) begin
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      blk_mode = 2'((blk + blk / 4) % 4);
      if (blk == 0) blk_seed = 64'd0;
      else if (blk == 1) blk_seed = '1;
      else blk_seed = {$urandom, $urandom};
      write_reg(lctg_pkg::CFG_MODE, {$urandom, 30'($urandom), blk_mode});
      write_reg(lctg_pkg::CFG_SEED, blk_seed);
      // layered runs long without restart so the counter wraps
      block_len = (blk_mode == lctg_pkg::MODE_LAYERED) ? 260 : 130;
      for (int i = 0; i < block_len; i++) begin
        if (i == 0) pending_requests.push_back(1'b1);
        else if (blk_mode == lctg_pkg::MODE_LAYERED) pending_requests.push_back(1'b0);
        else pending_requests.push_back($urandom_range(99) < 4);
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/lctg_pkg.sv
src/lctg_seq.sv
src/lctg_dp.sv
src/lcg_cell_topology_generator_top.sv
bench/tb_top.sv
